// ===== hw/rtl/sai_pkg.sv =====
package sai_pkg;

   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   // One finished result, handed from the engine to the response stage
   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      value_type            read_value;
   } result_type;

endpackage

// ===== hw/rtl/sai_channels.sv =====
interface sai_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic signed [sai_pkg::VALUE_W-1:0] value;
   logic [sai_pkg::INDEX_W-1:0]   index;

   modport source (output valid, operation, value, index, input ready);
   modport sink   (input valid, operation, value, index, output ready);
endinterface

interface sai_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [sai_pkg::COUNT_W-1:0]   count;
   logic signed [sai_pkg::VALUE_W-1:0] read_value;

   modport source (output valid, status, count, read_value, input ready);
   modport sink   (input valid, status, count, read_value, output ready);
endinterface

// ===== hw/rtl/sai_ram.sv =====
module sai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/sai_engine.sv =====
module sai_engine #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   sai_req_if.sink             req,
   output logic                res_valid,
   input  logic                res_ack,
   output sai_pkg::result_type res
);
   import sai_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SEARCH   = 8'b0000_0010,
      S_PROBE    = 8'b0000_0100,
      S_CHECK    = 8'b0000_1000,
      S_SHIFT_UP = 8'b0001_0000,
      S_SHIFT_DN = 8'b0010_0000,
      S_RDWAIT   = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   value_type         value_ff, value_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     count_ff, count_in;
   status_type        res_status_ff, res_status_in;
   value_type         res_rd_ff, res_rd_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [AW-1:0]     ram_raddr;
   value_type         ram_wdata;
   value_type         ram_rdata;

   logic [CW:0]       mid_sum;
   logic [CW-1:0]     mid;
   logic [CW-1:0]     ptr_dec;
   logic [CW-1:0]     ptr_inc;
   logic [CW-1:0]     lo_inc;
   logic [CW+5:0]     idx_wide;
   logic [CW+5:0]     cnt_wide;
   logic [CW+6:0]     cnt_out;

   sai_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Arithmetic helpers for the search and the shift pointer
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CW:1];
   assign ptr_dec  = ptr_ff - CW'(1);
   assign ptr_inc  = ptr_ff + CW'(1);
   assign lo_inc   = lo_ff + CW'(1);
   assign idx_wide = (CW+6)'(req.index);
   assign cnt_wide = (CW+6)'(count_ff);
   assign cnt_out  = (CW+7)'(count_ff);

   assign req.ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   assign res.status     = res_status_ff;
   assign res.count      = cnt_out[COUNT_W-1:0];
   assign res.read_value = res_rd_ff;

   // Sequencer: search, check, shift and read over the store
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      ptr_in        = ptr_ff;
      wr_addr_in    = wr_addr_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_rd_in     = res_rd_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_addr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in         = op_type'(req.operation);
               value_in      = req.value;
               lo_in         = '0;
               hi_in         = count_ff;
               res_status_in = ST_OK;
               res_rd_in     = '0;
               unique case (op_type'(req.operation))
                  OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_DELETE: begin
                     state_in = S_SEARCH;
                  end
                  OP_READ: begin
                     if (idx_wide < cnt_wide) begin
                        ram_raddr = idx_wide[AW-1:0];
                        state_in  = S_RDWAIT;
                     end else begin
                        res_status_in = ST_BAD_INDEX;
                        state_in      = S_DONE;
                     end
                  end
                  OP_NOP: begin
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               // probe the midpoint
               ram_raddr = mid[AW-1:0];
               mid_in    = mid;
               state_in  = S_PROBE;
            end else if (op_ff == OP_INSERT) begin
               ptr_in   = count_ff;
               pend_in  = 1'b0;
               state_in = S_SHIFT_UP;
            end else if (lo_ff >= count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               ram_raddr = lo_ff[AW-1:0];
               state_in  = S_CHECK;
            end
         end

         S_PROBE: begin
            if ($signed(ram_rdata) < $signed(value_ff)) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SEARCH;
         end

         S_CHECK: begin
            if (ram_rdata == value_ff) begin
               ptr_in   = lo_inc;
               pend_in  = 1'b0;
               state_in = S_SHIFT_DN;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end

         S_SHIFT_UP: begin
            // write back the entry fetched last cycle one place higher
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (ptr_ff > lo_ff) begin
               ram_raddr  = ptr_dec[AW-1:0];
               wr_addr_in = ptr_ff[AW-1:0];
               ptr_in     = ptr_dec;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = lo_ff[AW-1:0];
                  ram_wdata = value_ff;
                  count_in  = count_ff + CW'(1);
                  state_in  = S_DONE;
               end
            end
         end

         S_SHIFT_DN: begin
            // write back the entry fetched last cycle one place lower
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (ptr_ff < count_ff) begin
               ram_raddr  = ptr_ff[AW-1:0];
               wr_addr_in = ptr_dec[AW-1:0];
               ptr_in     = ptr_inc;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end
         end

         S_RDWAIT: begin
            res_rd_in = ram_rdata;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      ptr_ff        <= ptr_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_rd_ff     <= res_rd_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff))
      else $error("search bounds crossed");

   a_write_in_shift: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SHIFT_UP || state_ff == S_SHIFT_DN))
      else $error("store written outside a shift");

endmodule

// ===== hw/rtl/sorted_array_insert_delete.sv =====
// Sorted multiset of signed 32-bit values held in one single-port-write,
// registered-read memory of CAPACITY entries, plus an entry count. Each
// request is an insert, a delete or a read by index, and gives exactly one
// response with a status, the count after the operation and the value read.
// One request is worked at a time. A read passes the wait state for the
// registered memory read before it is done; a refused insert, a read beyond
// the count or the unused code goes straight to the done state. Insert and
// delete run a binary search, each memory probe passing a search and a probe
// state, then shift the later entries up or down (the shift streams one read
// and one write per cycle through the memory). The engine takes the next
// request in the cycle after it hands a result to the response register,
// which lets the next request in while a result waits to be taken. Reset
// clears the count at once; the memory itself is never cleared, since only
// entries below the count are read.
module sorted_array_insert_delete #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   sai_req_if.sink    req,
   sai_rsp_if.source  rsp
);
   import sai_pkg::*;

   logic        res_valid;
   logic        res_ack;
   result_type  res;

   logic        rsp_valid_ff;
   result_type  rsp_data_ff;

   sai_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .res       (res)
   );

   // Take a result whenever the response slot is empty or being drained
   assign res_ack = res_valid && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_ack) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_data_ff.status;
   assign rsp.count      = rsp_data_ff.count;
   assign rsp.read_value = rsp_data_ff.read_value;

endmodule
